FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // fixed field widths
   localparam int OPC_W  = 1;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int ATTR_W = 8;

   // derived widths
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FILL_W = $clog2(COLUMNS + 1);
   localparam int LIN_W  = $clog2(CELLS);
   localparam int MEM_DEPTH = ROWS * (2 ** COL_W);

   // reciprocal for cell number / COLUMNS: estimate is exact or one low
   localparam int RECIP_SHIFT = IDX_W + COL_W;
   localparam int RECIP_W     = IDX_W + 1;
   localparam int RECIP       = (2 ** RECIP_SHIFT) / COLUMNS;
   localparam int PROD_W      = IDX_W + RECIP_W;

   localparam logic [OPC_W-1:0]  OP_WRITE     = 1'b0;
   localparam logic [OPC_W-1:0]  OP_READ      = 1'b1;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd0;
   localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'd7;

   typedef struct packed {
      logic capture;
      logic write_exec;
      logic div;
      logic fix;
      logic map;
      logic mem_read;
      logic read_out;
   } tcw_cmd_type;

endpackage

FILE: rtl/core/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Text console writer: an 80 x 25 screen of character cells with a linear
// cursor. A request is taken when start is high and busy is low; each request
// gives exactly one result, shown for one cycle with rsp_strobe, and the
// receiver cannot stall it, so it must take every strobed result. A character
// write updates the cursor, the screen store and the scroll offset, then
// gives the result. A cell read goes through the cell-number-to-row/column
// split (reciprocal multiply, then a correction multiply and compare), the
// mapping through the rotating row offset and the registered read of the
// screen store, then gives the result. Scrolling moves no data: the top row
// is recycled as the new blank bottom row. Rows are blanked
// by per-row valid bits and fill counts, so no clearing pass runs after reset.
// Attributes always read as 7 for cells on screen, and 0 out of range.
module text_console_writer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tcw_pkg::OPC_W-1:0]    req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]    req_cell_index,
   output logic                         rsp_strobe,
   output logic [tcw_pkg::POS_W-1:0]    rsp_cursor_pos,
   output logic                         rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]   rsp_read_attr
);
   import tcw_pkg::*;

   tcw_cmd_type cmd;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_attr  (rsp_read_attr)
   );

endmodule

FILE: rtl/core/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tcw_pkg::OPC_W-1:0]   req_opcode,
   output logic                        busy,
   output logic                        rsp_strobe,
   output tcw_pkg::tcw_cmd_type        cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_DIV,
      ST_FIX,
      ST_MAP,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_opcode == OP_READ) ? ST_DIV : ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_DIV:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_MAP;
         ST_MAP:   state_in = ST_READ;
         ST_READ:  state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      busy_in   = (state_in != ST_IDLE);
      strobe_in = (state_ff == ST_WRITE) || (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      cmd.capture    = (state_ff == ST_IDLE) && start;
      cmd.write_exec = (state_ff == ST_WRITE);
      cmd.div        = (state_ff == ST_DIV);
      cmd.fix        = (state_ff == ST_FIX);
      cmd.map        = (state_ff == ST_MAP);
      cmd.mem_read   = (state_ff == ST_READ);
      cmd.read_out   = (state_ff == ST_OUT);
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

FILE: rtl/core/tcw_datapath.sv
`timescale 1ns / 1ps

module tcw_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  tcw_pkg::tcw_cmd_type         cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]    req_cell_index,
   output logic [tcw_pkg::POS_W-1:0]    rsp_cursor_pos,
   output logic                         rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]   rsp_read_attr
);
   import tcw_pkg::*;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   // captured request
   logic [CHAR_W-1:0] char_ff;
   logic [IDX_W-1:0]  idx_ff;

   // cursor and scroll state
   logic [LIN_W-1:0]  lin_ff, lin_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;

   // read path
   logic [IDX_W-1:0]  q_ff;
   logic [ROW_W-1:0]  rd_row_ff;
   logic [COL_W-1:0]  rd_col_ff;
   logic              rd_ok_ff;
   logic [ROW_W-1:0]  rd_phys_ff;
   logic              rd_rv_ff;

   // result
   logic [POS_W-1:0]  pos_ff;
   logic              scr_ff;
   logic [CHAR_W-1:0] rchar_ff;
   logic [ATTR_W-1:0] rattr_ff;

   logic [ROW_W-1:0]  cur_phys;
   logic              is_nl, last_col, last_row, row_end, scroll;
   logic [FILL_W-1:0] lin_step;
   logic [LIN_W:0]    lin_sum;
   logic [LIN_W+POS_W-1:0] lin_wide;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] qc;
   logic [PROD_W-1:0] rem;
   logic              rem_ge;
   logic              idx_ok;
   logic [IDX_W-1:0]  row_q;
   logic [PROD_W-1:0] col_r;

   logic [CHAR_W-1:0] ram_char;
   logic [FILL_W-1:0] ram_fill;
   logic              hit;
   logic              cell_wr;

   // write step
   always_comb begin
      cur_phys = phys_row(row_ff, top_ff);
      is_nl    = (char_ff == NEWLINE_CODE);
      last_col = (col_ff == COL_W'(COLUMNS - 1));
      last_row = (row_ff == ROW_W'(ROWS - 1));
      row_end  = is_nl || last_col;
      scroll   = row_end && last_row;
      lin_step = row_end ? (FILL_W'(COLUMNS) - FILL_W'(col_ff)) : FILL_W'(1);
      lin_sum  = (LIN_W+1)'(lin_ff) + (LIN_W+1)'(lin_step);
      cell_wr  = cmd.write_exec && !is_nl;

      row_in = row_ff;
      col_in = col_ff;
      lin_in = lin_ff;
      top_in = top_ff;
      if (scroll) begin
         row_in = ROW_W'(ROWS - 1);
         col_in = '0;
         lin_in = LIN_W'(CELLS - COLUMNS);
         top_in = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + ROW_W'(1);
      end else if (row_end) begin
         row_in = row_ff + ROW_W'(1);
         col_in = '0;
         lin_in = lin_sum[LIN_W-1:0];
      end else begin
         col_in = col_ff + COL_W'(1);
         lin_in = lin_sum[LIN_W-1:0];
      end

      row_valid_in = row_valid_ff;
      if (!is_nl) begin
         row_valid_in[cur_phys] = 1'b1;
      end
      // recycled top row becomes the blank bottom row
      if (scroll) begin
         row_valid_in[top_ff] = 1'b0;
      end
   end

   // read step arithmetic
   always_comb begin
      prod   = PROD_W'(idx_ff) * PROD_W'(RECIP);
      qc     = PROD_W'(q_ff) * PROD_W'(COLUMNS);
      rem    = PROD_W'(idx_ff) - qc;
      rem_ge = (rem >= PROD_W'(COLUMNS));
      row_q  = rem_ge ? q_ff + IDX_W'(1) : q_ff;
      col_r  = rem_ge ? rem - PROD_W'(COLUMNS) : rem;
      idx_ok = (PROD_W'(idx_ff) < PROD_W'(CELLS));
      hit    = rd_ok_ff && rd_rv_ff && (FILL_W'(rd_col_ff) < ram_fill);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         row_valid_ff <= '0;
      end else if (cmd.write_exec) begin
         lin_ff       <= lin_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      if (cmd.div) begin
         q_ff <= IDX_W'(prod >> RECIP_SHIFT);
      end
      if (cmd.fix) begin
         rd_ok_ff  <= idx_ok;
         rd_row_ff <= idx_ok ? ROW_W'(row_q) : '0;
         rd_col_ff <= idx_ok ? COL_W'(col_r) : '0;
      end
      if (cmd.map) begin
         rd_phys_ff <= phys_row(rd_row_ff, top_ff);
      end
      if (cmd.mem_read) begin
         rd_rv_ff <= row_valid_ff[rd_phys_ff];
      end
      if (cmd.write_exec) begin
         pos_ff   <= lin_wide[POS_W-1:0];
         scr_ff   <= scroll;
         rchar_ff <= '0;
         rattr_ff <= '0;
      end else if (cmd.read_out) begin
         pos_ff   <= lin_wide[POS_W-1:0];
         scr_ff   <= 1'b0;
         rchar_ff <= hit ? ram_char : BLANK_CHAR;
         rattr_ff <= rd_ok_ff ? BLANK_ATTR : '0;
      end
   end

   assign lin_wide = cmd.write_exec ? (LIN_W+POS_W)'(lin_in) : (LIN_W+POS_W)'(lin_ff);

   // characters per cell, addressed by physical row and column
   tcw_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MEM_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (cell_wr),
      .wr_addr ({cur_phys, col_ff}),
      .wr_data (char_ff),
      .rd_addr ({rd_phys_ff, rd_col_ff}),
      .rd_data (ram_char)
   );

   // number of leading columns written since the row was last blanked
   tcw_ram #(
      .WIDTH (FILL_W),
      .DEPTH (ROWS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (cell_wr),
      .wr_addr (cur_phys),
      .wr_data (FILL_W'(col_ff) + FILL_W'(1)),
      .rd_addr (rd_phys_ff),
      .rd_data (ram_fill)
   );

   assign rsp_cursor_pos = pos_ff;
   assign rsp_scrolled   = scr_ff;
   assign rsp_read_char  = rchar_ff;
   assign rsp_read_attr  = rattr_ff;

endmodule

FILE: rtl/core/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         rsp_strobe,
   input  logic [tcw_pkg::POS_W-1:0]    rsp_cursor_pos,
   input  logic                         rsp_scrolled,
   input  logic [tcw_pkg::CHAR_W-1:0]   rsp_read_char,
   input  logic [tcw_pkg::ATTR_W-1:0]   rsp_read_attr
);
   import tcw_pkg::*;

   // a taken request holds off the next one
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without going busy");

   // every request passes through a working state before its result, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> int'(rsp_cursor_pos) < CELLS)
      else $error("cursor beyond last cell");

   a_scroll_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_scrolled |->
         rsp_cursor_pos == POS_W'(CELLS - COLUMNS) &&
         rsp_read_char == '0 && rsp_read_attr == '0)
      else $error("scroll result not at start of bottom row");

   a_attr_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_read_attr == BLANK_ATTR || rsp_read_attr == '0)
      else $error("unexpected attribute");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_scrolled   (rsp_scrolled),
   .rsp_read_char  (rsp_read_char),
   .rsp_read_attr  (rsp_read_attr)
);

FILE: sim/text_console_writer_unit_test.sv
`timescale 1ns / 1ps

module text_console_writer_unit_test;
   import tcw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 880;
   localparam int CALM_TAIL      = 120;
   localparam int SETTLE_CYCLES  = 12;

   typedef struct {
      logic [OPC_W-1:0]  opcode;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
      bit                drain_first;
   } console_request_type;

   typedef struct {
      logic [POS_W-1:0]  cursor_pos;
      logic              scrolled;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
   } console_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OPC_W-1:0]    req_opcode;
   logic [CHAR_W-1:0]   req_char_code;
   logic [IDX_W-1:0]    req_cell_index;
   logic                rsp_strobe;
   logic [POS_W-1:0]    rsp_cursor_pos;
   logic                rsp_scrolled;
   logic [CHAR_W-1:0]   rsp_read_char;
   logic [ATTR_W-1:0]   rsp_read_attr;

   console_request_type pending_requests[$];
   console_result_type  expected_results[$];
   console_request_type current_request;

   // predicted screen contents and cursor
   logic [CHAR_W-1:0] screen_char [CELLS];
   logic [ATTR_W-1:0] screen_attr [CELLS];
   int unsigned       cursor_cell;

   int requests_sent;
   int results_seen;
   int mismatch_count;
   int idle_cycles_left;
   int stall_cycles;
   int writes_done;
   int newlines_done;
   int reads_done;
   int misses_done;
   int scrolls_done;

   text_console_writer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_attr  (rsp_read_attr)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic console_result_type apply_console_request(console_request_type req);
      console_result_type res;
      int i;
      res.cursor_pos = '0;
      res.scrolled   = 1'b0;
      res.read_char  = '0;
      res.read_attr  = '0;
      if (req.opcode == OP_WRITE) begin
         writes_done++;
         if (cursor_cell >= CELLS) cursor_cell = 0;
         if (req.char_code == NEWLINE_CODE) begin
            newlines_done++;
            cursor_cell = (cursor_cell / COLUMNS + 1) * COLUMNS;
         end else begin
            screen_char[cursor_cell] = req.char_code;
            cursor_cell++;
         end
         if (cursor_cell >= CELLS) begin
            // shift every row up one and blank the bottom row
            for (i = 0; i < CELLS - COLUMNS; i++) begin
               screen_char[i] = screen_char[i + COLUMNS];
               screen_attr[i] = screen_attr[i + COLUMNS];
            end
            for (i = CELLS - COLUMNS; i < CELLS; i++) begin
               screen_char[i] = BLANK_CHAR;
               screen_attr[i] = BLANK_ATTR;
            end
            cursor_cell  = CELLS - COLUMNS;
            res.scrolled = 1'b1;
            scrolls_done++;
         end
      end else begin
         reads_done++;
         if (req.cell_index < CELLS) begin
            res.read_char = screen_char[req.cell_index];
            res.read_attr = screen_attr[req.cell_index];
         end else begin
            misses_done++;
         end
      end
      res.cursor_pos = cursor_cell[POS_W-1:0];
      return res;
   endfunction

   task automatic queue_request(logic [OPC_W-1:0] op, logic [CHAR_W-1:0] code,
                                logic [IDX_W-1:0] idx, bit drain);
      console_request_type req;
      req.opcode      = op;
      req.char_code   = code;
      req.cell_index  = idx;
      req.drain_first = drain;
      pending_requests.push_back(req);
   endtask

   task automatic queue_read(logic [IDX_W-1:0] idx, bit drain);
      queue_request(OP_READ, CHAR_W'($urandom_range(0, 255)), idx, drain);
   endtask

   task automatic queue_write(logic [CHAR_W-1:0] code);
      queue_request(OP_WRITE, code, IDX_W'($urandom_range(0, 2047)), 1'b0);
   endtask

   // driver: launch queued requests, predict each one as it is taken
   always @(posedge clock) begin : drive_requests
      int outstanding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(apply_console_request(current_request));
            requests_sent++;
         end
         if (!start || !busy) begin
            outstanding = requests_sent - results_seen - (rsp_strobe ? 1 : 0);
            if (idle_cycles_left > 0) begin
               idle_cycles_left--;
               start <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               start <= 1'b0;
            end else if (pending_requests[0].drain_first && outstanding > 0) begin
               // hold until every result in flight has come back
               start <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL &&
                         $urandom_range(0, 5) == 0) begin
               idle_cycles_left = $urandom_range(0, 14);
               start <= 1'b0;
            end else begin
               current_request = pending_requests.pop_front();
               req_opcode     <= current_request.opcode;
               req_char_code  <= current_request.char_code;
               req_cell_index <= current_request.cell_index;
               start          <= 1'b1;
            end
         end
      end
   end

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // monitor: every strobed result against the oldest prediction
   always @(posedge clock) begin : check_results
      console_result_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual cursor_pos=%0d",
                     $time, rsp_cursor_pos);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("cursor_pos", 16'(want.cursor_pos), 16'(rsp_cursor_pos));
            compare_field("scrolled", 16'(want.scrolled), 16'(rsp_scrolled));
            compare_field("read_char", 16'(want.read_char), 16'(rsp_read_char));
            compare_field("read_attr", 16'(want.read_attr), 16'(rsp_read_attr));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $time, stall_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int added;
      int sel;
      int len;
      int k;
      int r;
      int mid;
      console_request_type tmp;

      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = '0;
      req_char_code  = '0;
      req_cell_index = '0;
      cursor_cell    = 0;
      requests_sent  = 0;
      results_seen   = 0;
      mismatch_count = 0;
      idle_cycles_left = 0;
      stall_cycles   = 0;
      writes_done    = 0;
      newlines_done  = 0;
      reads_done     = 0;
      misses_done    = 0;
      scrolls_done   = 0;
      for (k = 0; k < CELLS; k++) begin
         screen_char[k] = BLANK_CHAR;
         screen_attr[k] = BLANK_ATTR;
      end

      // directed: blank screen, edge indexes, extreme bytes, newline cases
      queue_read(IDX_W'(0), 1'b0);
      queue_read(IDX_W'(CELLS - 1), 1'b0);
      queue_read(IDX_W'(CELLS), 1'b0);
      queue_read({IDX_W{1'b1}}, 1'b0);
      queue_write(8'd0);
      queue_write(8'd255);
      queue_write(8'd65);
      queue_write(NEWLINE_CODE);
      queue_write(8'd11);
      queue_read(IDX_W'(0), 1'b1);
      queue_read(IDX_W'(1), 1'b0);
      queue_read(IDX_W'(2), 1'b0);
      queue_read(IDX_W'(80), 1'b0);
      queue_read(IDX_W'(81), 1'b0);
      queue_write(NEWLINE_CODE);
      queue_write(NEWLINE_CODE);
      queue_read(IDX_W'(159), 1'b0);
      queue_read(IDX_W'(1024), 1'b0);

      // random: mostly lines of text ended by newline, reads between them
      added = 0;
      while (added < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            r = $urandom_range(0, 19);
            if (r < 14)      len = $urandom_range(0, 6);
            else if (r < 18) len = $urandom_range(7, 40);
            else             len = $urandom_range(70, 100);
            for (k = 0; k < len; k++) queue_write(CHAR_W'($urandom_range(0, 255)));
            queue_write(NEWLINE_CODE);
            added += len + 1;
         end else if (sel < 92) begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) begin
               r = $urandom_range(0, 9);
               if (r < 5)
                  queue_read(IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1)), 1'b0);
               else if (r < 8) queue_read(IDX_W'($urandom_range(0, CELLS - 1)), 1'b0);
               else            queue_read(IDX_W'($urandom_range(CELLS, 2047)), 1'b0);
            end
            added += len;
         end else begin
            queue_request(OPC_W'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                          IDX_W'($urandom_range(0, 2047)), 1'b0);
            added++;
         end
      end
      mid = pending_requests.size() / 2;
      tmp = pending_requests[mid];
      tmp.drain_first = 1'b1;
      pending_requests[mid] = tmp;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_requests.size() != 0 || start || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_results.size() != 0)
         $display("%0t: %0d results never arrived", $time, expected_results.size());
      $display("Ran %0d requests: %0d writes with %0d newlines, %0d scrolls,",
               requests_sent, writes_done, newlines_done, scrolls_done);
      $display("and %0d cell reads of which %0d were off screen.", reads_done, misses_done);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: text_console_writer_unit.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_unit.sv
rtl/core/tcw_checker.sv
sim/text_console_writer_unit_test.sv
